[rtl/core/mie_pkg.sv]
package mie_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  // Control from the sequencer to the quotient unit
  typedef struct packed {
    logic init;
    logic step;
  } div_ctrl_t;

endpackage

[rtl/core/mie_in_if.sv]
interface mie_in_if
  import mie_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink (input valid, input value, input modulus, output ready);
endinterface

[rtl/core/mie_out_if.sv]
interface mie_out_if
  import mie_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] coefficient;
  logic [WIDTH-1:0] divisor;
  logic             has_inverse;
  logic             error;

  modport source (output valid, output coefficient, output divisor, output has_inverse,
                  output error, input ready);
  modport sink (input valid, input coefficient, input divisor, input has_inverse,
                input error, output ready);
endinterface

[rtl/core/mie_div_unit.sv]
// Restoring divider, one quotient bit per step, MSB first. The quotient is
// folded straight into acc = q * mult by shift-and-add, so no quotient
// register and no multiplier are needed.
module mie_div_unit
  import mie_pkg::*;
(
  input  logic             clk,
  input  div_ctrl_t        ctrl,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  input  logic [WIDTH-1:0] mult,
  output logic [WIDTH-1:0] rem,
  output logic [WIDTH-1:0] acc
);

  logic [WIDTH-1:0] dvd;
  logic [WIDTH+1:0] diff;
  logic             ge;

  assign diff = {1'b0, rem, dvd[WIDTH-1]} - {2'b00, divisor};
  assign ge   = ~diff[WIDTH+1];

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      rem <= '0;
      dvd <= dividend;
      acc <= '0;
    end else if (ctrl.step) begin
      rem <= ge ? diff[WIDTH-1:0] : {rem[WIDTH-2:0], dvd[WIDTH-1]};
      dvd <= {dvd[WIDTH-2:0], 1'b0};
      acc <= {acc[WIDTH-2:0], 1'b0} + (ge ? mult : '0);
    end
  end

endmodule

[rtl/core/modular_inverse_unit_core.sv]
// Channel | Dir | Beat fields
// req     | in  | value, modulus
// rsp     | out | coefficient, divisor, has_inverse, error
//
// One item at a time; req.ready is high only while idle.
// Each Euclid iteration runs a test, WIDTH quotient bits from the bit-serial
// divider, then an update; after the last iteration a reduction step and the
// output step follow. A zero modulus goes straight to the output step.
// Reset (rst, synchronous) returns to idle and drops a pending rsp beat.
// A result waits in the rsp register; the block accepts a new item meanwhile
// and stalls only at the end of that next item if rsp is still full.
module modular_inverse_unit_core
  import mie_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  mie_in_if.sink   req,
  mie_out_if.source rsp
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TEST = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_RED  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] r_old, r, s_old, s, m;
  logic             neg, err;
  logic [WIDTH-1:0] rem, acc;
  logic             take, out_free;
  div_ctrl_t        dctrl;

  assign req.ready = (state == ST_IDLE);
  assign take      = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  assign dctrl.init = (state == ST_TEST) && (r != '0);
  assign dctrl.step = (state == ST_DIV);

  mie_div_unit u_div (
    .clk      (clk),
    .ctrl     (dctrl),
    .dividend (r_old),
    .divisor  (r),
    .mult     (s),
    .rem      (rem),
    .acc      (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // Drop the beat once taken, unless a new one is loaded this cycle
      if (rsp.valid && rsp.ready && state != ST_FIN) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            state <= (req.modulus == '0) ? ST_FIN : ST_TEST;
          end
        end
        ST_TEST: begin
          cnt   <= '0;
          state <= (r == '0) ? ST_RED : ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(WIDTH - 1)) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: state <= ST_TEST;
        ST_RED: state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            rsp.valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Coefficient magnitudes only; neg tracks the alternating sign
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          r_old <= req.value;
          r     <= req.modulus;
          m     <= req.modulus;
          s_old <= WIDTH'(1);
          s     <= '0;
          neg   <= 1'b0;
          err   <= (req.modulus == '0);
        end
      end
      ST_UPD: begin
        r_old <= r;
        r     <= rem;
        s_old <= s;
        s     <= s_old + acc;
        neg   <= ~neg;
      end
      // s_old never exceeds m, so one conditional subtract reduces it
      ST_RED: s_old <= (s_old >= m) ? s_old - m : s_old;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      if (err) begin
        rsp.coefficient <= '0;
        rsp.divisor     <= '0;
        rsp.has_inverse <= 1'b0;
        rsp.error       <= 1'b1;
      end else begin
        rsp.coefficient <= (neg && s_old != '0) ? m - s_old : s_old;
        rsp.divisor     <= r_old;
        rsp.has_inverse <= (r_old == WIDTH'(1));
        rsp.error       <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/mie_checker.sv]
module mie_checker
  import mie_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WIDTH-1:0] coefficient,
  input logic [WIDTH-1:0] divisor,
  input logic             has_inverse,
  input logic             error
);

  // Busy after every accepted beat
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coefficient) && $stable(divisor)
      && $stable(has_inverse) && $stable(error))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> coefficient == '0 && divisor == '0 && !has_inverse)
    else $error("error beat carries data");

  a_inv_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error |-> has_inverse == (divisor == WIDTH'(1)))
    else $error("has_inverse disagrees with divisor");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error |-> divisor != '0)
    else $error("zero gcd with nonzero modulus");

endmodule

bind modular_inverse_unit_core mie_checker u_mie_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .coefficient (rsp.coefficient),
  .divisor     (rsp.divisor),
  .has_inverse (rsp.has_inverse),
  .error       (rsp.error)
);
